/* hw/rtl/fvcw_pkg.sv */
// ============================================================================
// Flow color wheel package
// Shared constants, tables and helper functions for the flow color wheel.
// ============================================================================
package fvcw_pkg;

    // Default flow component width and fixed-point format.
    parameter int FLOW_WIDTH_DEF = 20;
    parameter int FRAC_BITS      = 8;

    // Full-scale radius register.
    parameter int RAD_WIDTH = 19;
    parameter logic [RAD_WIDTH-1:0] RADIUS_RESET = RAD_WIDTH'(30 << FRAC_BITS);

    // Color wheel geometry.
    parameter int NCOLS   = 55;
    parameter int PHASE_W = 16;
    parameter int HUE_P_W = PHASE_W + 6;
    parameter int KIDX_W  = 6;
    parameter int COLX_W  = 24;

    // Angle unit.
    parameter int CORDIC_STEPS = 14;
    parameter int CORDIC_SCALE = 20;
    parameter int ANGLE_W      = 17;
    // Register stages of the unit, from its input to its registered phase.
    parameter int CORDIC_LAT   = CORDIC_STEPS + 2;

    // Normalized radius, Q12 with saturation at one.
    parameter int RQ_W   = 13;
    parameter logic [RQ_W-1:0] RQ_MAX = RQ_W'(4096);

    // One color as three 8-bit channels: [0] red, [1] green, [2] blue.
    typedef logic [2:0][7:0] rgb_t;

    // Ramps of the wheel segments, 255 * j / n truncated.
    parameter logic [7:0] RAMP6 [6] = '{8'd0, 8'd42, 8'd85, 8'd127, 8'd170, 8'd212};
    parameter logic [7:0] RAMP4 [4] = '{8'd0, 8'd63, 8'd127, 8'd191};
    parameter logic [7:0] RAMP11 [11] = '{8'd0, 8'd23, 8'd46, 8'd69, 8'd92, 8'd115,
                                          8'd139, 8'd162, 8'd185, 8'd208, 8'd231};
    parameter logic [7:0] RAMP13 [13] = '{8'd0, 8'd19, 8'd39, 8'd58, 8'd78, 8'd98,
                                          8'd117, 8'd137, 8'd156, 8'd176, 8'd196,
                                          8'd215, 8'd235};

    // Arctangent of 2^-i in units of 2^-16 turn.
    function automatic logic [13:0] atan_turn(input logic [3:0] idx);
        logic [13:0] a;
        unique case (idx)
            4'd0:    a = 14'd8192;
            4'd1:    a = 14'd4836;
            4'd2:    a = 14'd2555;
            4'd3:    a = 14'd1297;
            4'd4:    a = 14'd651;
            4'd5:    a = 14'd326;
            4'd6:    a = 14'd163;
            4'd7:    a = 14'd81;
            4'd8:    a = 14'd41;
            4'd9:    a = 14'd20;
            4'd10:   a = 14'd10;
            4'd11:   a = 14'd5;
            4'd12:   a = 14'd3;
            4'd13:   a = 14'd1;
            default: a = 14'd0;
        endcase
        return a;
    endfunction

    // One entry of the color wheel.
    function automatic rgb_t wheel_entry(input logic [KIDX_W-1:0] k);
        rgb_t c;
        logic [KIDX_W-1:0] j;
        c = '0;
        j = '0;
        if (k < KIDX_W'(15)) begin
            c[0] = 8'd255;
            c[1] = 8'(k * 17);
        end
        else if (k < KIDX_W'(21)) begin
            j = k - KIDX_W'(15);
            c[0] = 8'd255 - RAMP6[j[2:0]];
            c[1] = 8'd255;
        end
        else if (k < KIDX_W'(25)) begin
            j = k - KIDX_W'(21);
            c[1] = 8'd255;
            c[2] = RAMP4[j[1:0]];
        end
        else if (k < KIDX_W'(36)) begin
            j = k - KIDX_W'(25);
            c[1] = 8'd255 - RAMP11[j[3:0]];
            c[2] = 8'd255;
        end
        else if (k < KIDX_W'(49)) begin
            j = k - KIDX_W'(36);
            c[0] = RAMP13[j[3:0]];
            c[2] = 8'd255;
        end
        else begin
            j = k - KIDX_W'(49);
            if (j > KIDX_W'(5)) begin
                j = KIDX_W'(5);
            end
            c[0] = 8'd255;
            c[2] = 8'd255 - RAMP6[j[2:0]];
        end
        return c;
    endfunction

endpackage

/* hw/rtl/fvcw_cordic.sv */
// ============================================================================
// Flow color wheel phase unit
// Pipelined octant fold and vectoring-mode rotation that turns a flow vector
// into its angle in units of 2^-16 turn, one stage per rotation step.
// ============================================================================
module fvcw_cordic #(
    parameter int FLOW_WIDTH = fvcw_pkg::FLOW_WIDTH_DEF
) (
    input  logic                                 clk,
    input  logic                                 en,
    input  logic signed [FLOW_WIDTH-1:0]         u,
    input  logic signed [FLOW_WIDTH-1:0]         v,
    output logic        [fvcw_pkg::PHASE_W-1:0]  phase
);

    localparam int STEPS = fvcw_pkg::CORDIC_STEPS;
    localparam int SCALE = fvcw_pkg::CORDIC_SCALE;
    localparam int CW    = FLOW_WIDTH + SCALE + 2;
    localparam int TW    = fvcw_pkg::ANGLE_W;

    logic signed [CW-1:0] x_reg     [0:STEPS];
    logic signed [CW-1:0] y_reg     [0:STEPS];
    logic signed [TW-1:0] t_reg     [0:STEPS];
    logic                 swap_reg  [0:STEPS];
    logic                 uneg_reg  [0:STEPS];
    logic                 vneg_reg  [0:STEPS];
    logic                 zero_reg  [0:STEPS];
    logic [fvcw_pkg::PHASE_W-1:0] phase_reg;

    // Fold the vector into the first octant.
    logic [FLOW_WIDTH-1:0] au;
    logic [FLOW_WIDTH-1:0] av;
    logic [FLOW_WIDTH-1:0] mx;
    logic [FLOW_WIDTH-1:0] mn;
    logic                  sw;

    always_comb
    begin
        au = u[FLOW_WIDTH-1] ? (~u + FLOW_WIDTH'(1)) : u;
        av = v[FLOW_WIDTH-1] ? (~v + FLOW_WIDTH'(1)) : v;
        sw = av > au;
        mx = sw ? av : au;
        mn = sw ? au : av;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0]    <= $signed({2'b00, mx, {SCALE{1'b0}}});
            y_reg[0]    <= $signed({2'b00, mn, {SCALE{1'b0}}});
            t_reg[0]    <= '0;
            swap_reg[0] <= sw;
            uneg_reg[0] <= u[FLOW_WIDTH-1];
            vneg_reg[0] <= v[FLOW_WIDTH-1];
            zero_reg[0] <= (mx == '0);
        end
    end

    // One rotation step per stage.
    for (genvar i = 0; i < STEPS; i++)
    begin : g_step
        logic signed [CW-1:0] xs;
        logic signed [CW-1:0] ys;
        logic signed [TW-1:0] at;

        always_comb
        begin
            xs = x_reg[i] >>> i;
            ys = y_reg[i] >>> i;
            at = $signed(TW'(fvcw_pkg::atan_turn(4'(i))));
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (y_reg[i] >= 0)
                begin
                    x_reg[i+1] <= x_reg[i] + ys;
                    y_reg[i+1] <= y_reg[i] - xs;
                    t_reg[i+1] <= t_reg[i] + at;
                end
                else
                begin
                    x_reg[i+1] <= x_reg[i] - ys;
                    y_reg[i+1] <= y_reg[i] + xs;
                    t_reg[i+1] <= t_reg[i] - at;
                end
                swap_reg[i+1] <= swap_reg[i];
                uneg_reg[i+1] <= uneg_reg[i];
                vneg_reg[i+1] <= vneg_reg[i];
                zero_reg[i+1] <= zero_reg[i];
            end
        end
    end

    // Clamp the octant angle, unfold it and wrap to one turn.
    logic signed [TW-1:0] tl;
    logic [14:0]          tc;
    logic [14:0]          ts;
    logic [TW-1:0]        ph;

    always_comb
    begin
        tl = t_reg[STEPS];
        if (zero_reg[STEPS] || tl < 0)
        begin
            tc = '0;
        end
        else if (tl > $signed(TW'(8192)))
        begin
            tc = 15'd8192;
        end
        else
        begin
            tc = 15'(tl);
        end
        ts = swap_reg[STEPS] ? (15'd16384 - tc) : tc;
        priority if (!uneg_reg[STEPS] && !vneg_reg[STEPS])
        begin
            ph = TW'(ts);
        end
        else if (uneg_reg[STEPS] && !vneg_reg[STEPS])
        begin
            ph = TW'(32768) - TW'(ts);
        end
        else if (uneg_reg[STEPS])
        begin
            ph = TW'(32768) + TW'(ts);
        end
        else
        begin
            ph = TW'(65536) - TW'(ts);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            phase_reg <= ph[fvcw_pkg::PHASE_W-1:0];
        end
    end

    assign phase = phase_reg;

endmodule

/* hw/rtl/fvcw_isqrt.sv */
// ============================================================================
// Flow color wheel square root
// Pipelined digit-by-digit integer square root of (sum of squares << 24),
// one result bit per stage.
// ============================================================================
module fvcw_isqrt #(
    parameter int FLOW_WIDTH = fvcw_pkg::FLOW_WIDTH_DEF
) (
    input  logic                      clk,
    input  logic                      en,
    input  logic [2*FLOW_WIDTH-1:0]   rad,
    output logic [FLOW_WIDTH+11:0]    root
);

    localparam int QW = FLOW_WIDTH + 12;
    localparam int NW = 2 * QW;

    logic [QW+1:0] rem_reg  [0:QW-1];
    logic [QW-1:0] root_reg [0:QW-1];
    logic [NW-1:0] rad_reg  [0:QW-1];

    for (genvar k = 0; k < QW; k++)
    begin : g_digit
        logic [QW+1:0] p_rem;
        logic [QW-1:0] p_root;
        logic [NW-1:0] p_rad;
        logic [QW+1:0] rem_sh;
        logic [QW+1:0] trial;
        logic          ge;

        // Previous partial result, or the fresh radicand in the first stage.
        if (k == 0)
        begin : g_first
            assign p_rem  = '0;
            assign p_root = '0;
            assign p_rad  = {rad, 24'd0};
        end
        else
        begin : g_next
            assign p_rem  = rem_reg[k-1];
            assign p_root = root_reg[k-1];
            assign p_rad  = rad_reg[k-1];
        end

        // Bring down two radicand bits and try the next root bit.
        always_comb
        begin
            rem_sh = {p_rem[QW-1:0], p_rad[NW-1:NW-2]};
            trial  = {p_root, 2'b01};
            ge     = rem_sh >= trial;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k]  <= ge ? (rem_sh - trial) : rem_sh;
                root_reg[k] <= {p_root[QW-2:0], ge};
                rad_reg[k]  <= p_rad << 2;
            end
        end
    end

    assign root = root_reg[QW-1];

endmodule

/* hw/rtl/flow_vector_to_color_wheel_core.sv */
// ============================================================================
// Flow vector to color wheel core
// Turns one signed fixed-point flow vector per beat into an RGB color: the
// direction picks a hue on a 55-entry wheel, the magnitude against the
// full-scale radius fades it from white or darkens it; unknown gives black.
//
//   Channel  Signals                                   Direction
//   config   cfg_we, cfg_wdata                         in, write only
//   input    in_valid/in_ready, flow_u, flow_v,        in
//            flow_invalid
//   output   out_valid/out_ready, red, green, blue     out
//
// A beat is accepted every cycle while the output is not stalled; the depth
// is mainly set by the square root (one bit per stage) followed by the
// radius division (one quotient bit per stage).
// Reset clears the valid bits and loads the radius register with 30 pixels.
// When the output holds a beat that is not taken, the whole pipeline holds
// and the input is not ready; nothing is lost or repeated.
// ============================================================================
module flow_vector_to_color_wheel_core #(
    parameter int FLOW_WIDTH = fvcw_pkg::FLOW_WIDTH_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [fvcw_pkg::RAD_WIDTH-1:0]      cfg_wdata,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic signed [FLOW_WIDTH-1:0]        flow_u,
    input  logic signed [FLOW_WIDTH-1:0]        flow_v,
    input  logic                                flow_invalid,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [7:0]                          red,
    output logic [7:0]                          green,
    output logic [7:0]                          blue
);

    localparam int RAD_W    = fvcw_pkg::RAD_WIDTH;
    localparam int RR_W     = 2 * RAD_W;
    localparam int SUM_W    = 2 * FLOW_WIDTH;
    localparam int CMP_W    = (SUM_W > RR_W) ? SUM_W : RR_W;
    localparam int SQ_W     = FLOW_WIDTH + 12;
    localparam int RQ_W     = fvcw_pkg::RQ_W;
    localparam int COLX_W   = fvcw_pkg::COLX_W;
    localparam int KW       = fvcw_pkg::KIDX_W;
    localparam int PROD_W   = RQ_W + COLX_W;
    localparam int ROOT_IDX = 2 + SQ_W;
    localparam int DIV_IDX  = ROOT_IDX + RQ_W;
    localparam int HUE_IDX  = fvcw_pkg::CORDIC_LAT + 2;
    localparam int SB_LEN   = DIV_IDX - 2;
    localparam int COL_LEN  = DIV_IDX - HUE_IDX;
    localparam int LAST     = DIV_IDX + 2;

    // Full-scale radius register; zero acts as one.
    logic [RAD_W-1:0] radius_reg;
    logic [RAD_W-1:0] r_eff;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg <= fvcw_pkg::RADIUS_RESET;
        end
        else if (cfg_we)
        begin
            radius_reg <= cfg_wdata;
        end
    end

    assign r_eff = (radius_reg == '0) ? RAD_W'(1) : radius_reg;

    // Global advance: every stage moves unless the output beat is stuck.
    logic adv;
    logic val_reg [0:LAST];

    assign adv      = !val_reg[LAST] || out_ready;
    assign in_ready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i <= LAST; i++)
            begin
                val_reg[i] <= 1'b0;
            end
        end
        else if (adv)
        begin
            val_reg[0] <= in_valid;
            for (int i = 1; i <= LAST; i++)
            begin
                val_reg[i] <= val_reg[i-1];
            end
        end
    end

    // Input register.
    logic signed [FLOW_WIDTH-1:0] u0_reg;
    logic signed [FLOW_WIDTH-1:0] v0_reg;
    logic                         inv0_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            u0_reg   <= flow_u;
            v0_reg   <= flow_v;
            inv0_reg <= flow_invalid;
        end
    end

    // Squares of the components and of the radius.
    logic signed [SUM_W-1:0] usq;
    logic signed [SUM_W-1:0] vsq;
    logic [SUM_W-1:0]        uu1_reg;
    logic [SUM_W-1:0]        vv1_reg;
    logic [RR_W-1:0]         rr1_reg;
    logic                    inv1_reg;

    assign usq = u0_reg * u0_reg;
    assign vsq = v0_reg * v0_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            uu1_reg  <= $unsigned(usq);
            vv1_reg  <= $unsigned(vsq);
            rr1_reg  <= RR_W'(r_eff) * RR_W'(r_eff);
            inv1_reg <= inv0_reg;
        end
    end

    // Sum of squares and the inside-radius test.
    logic [SUM_W-1:0] sumsq;
    logic [SUM_W-1:0] sumsq2_reg;
    logic             inside2_reg;
    logic             inv2_reg;

    assign sumsq = uu1_reg + vv1_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sumsq2_reg  <= sumsq;
            inside2_reg <= CMP_W'(sumsq) <= CMP_W'(rr1_reg);
            inv2_reg    <= inv1_reg;
        end
    end

    // Magnitude, scaled by 2^12.
    logic [SQ_W-1:0] root_w;

    fvcw_isqrt #(
        .FLOW_WIDTH (FLOW_WIDTH)
    ) u_isqrt (
        .clk  (clk),
        .en   (adv),
        .rad  (sumsq2_reg),
        .root (root_w)
    );

    // Division of the magnitude by the radius, one quotient bit per stage.
    logic [RAD_W-1:0] drem_reg [0:RQ_W-1];
    logic [RQ_W-1:0]  dq_reg   [0:RQ_W-1];
    logic [RQ_W-1:0]  dlow_reg [0:RQ_W-1];

    for (genvar j = 0; j < RQ_W; j++)
    begin : g_div
        logic [RAD_W-1:0] p_rem;
        logic [RQ_W-1:0]  p_q;
        logic [RQ_W-1:0]  p_low;
        logic [RAD_W:0]   trial;
        logic [RAD_W:0]   diff;
        logic             ge;

        if (j == 0)
        begin : g_first
            assign p_rem = RAD_W'(root_w >> RQ_W);
            assign p_q   = '0;
            assign p_low = root_w[RQ_W-1:0];
        end
        else
        begin : g_next
            assign p_rem = drem_reg[j-1];
            assign p_q   = dq_reg[j-1];
            assign p_low = dlow_reg[j-1];
        end

        always_comb
        begin
            trial = {p_rem, p_low[RQ_W-1]};
            ge    = trial >= {1'b0, r_eff};
            diff  = trial - {1'b0, r_eff};
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                drem_reg[j] <= ge ? diff[RAD_W-1:0] : trial[RAD_W-1:0];
                dq_reg[j]   <= {p_q[RQ_W-2:0], ge};
                dlow_reg[j] <= p_low << 1;
            end
        end
    end

    // Inside and invalid flags follow the magnitude path.
    logic sb_inside_reg [0:SB_LEN-1];
    logic sb_inv_reg    [0:SB_LEN-1];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sb_inside_reg[0] <= inside2_reg;
            sb_inv_reg[0]    <= inv2_reg;
            for (int i = 1; i < SB_LEN; i++)
            begin
                sb_inside_reg[i] <= sb_inside_reg[i-1];
                sb_inv_reg[i]    <= sb_inv_reg[i-1];
            end
        end
    end

    // Direction of the vector.
    logic [fvcw_pkg::PHASE_W-1:0] phase_w;

    fvcw_cordic #(
        .FLOW_WIDTH (FLOW_WIDTH)
    ) u_cordic (
        .clk   (clk),
        .en    (adv),
        .u     (u0_reg),
        .v     (v0_reg),
        .phase (phase_w)
    );

    // Wheel position: entry index and blend fraction.
    logic [fvcw_pkg::HUE_P_W-1:0] hue_p;
    logic [KW-1:0]                k0_reg;
    logic [15:0]                  f_reg;

    assign hue_p = fvcw_pkg::HUE_P_W'(phase_w) *
                   fvcw_pkg::HUE_P_W'(fvcw_pkg::NCOLS - 1);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            k0_reg <= hue_p[fvcw_pkg::HUE_P_W-1:16];
            f_reg  <= hue_p[15:0];
        end
    end

    // Blend of two adjacent wheel entries.
    logic [KW-1:0]        k1;
    fvcw_pkg::rgb_t       c0;
    fvcw_pkg::rgb_t       c1;
    logic [16:0]          fw0;
    logic [COLX_W-1:0]    colx_reg [3];

    always_comb
    begin
        k1  = (k0_reg == KW'(fvcw_pkg::NCOLS - 1)) ? '0 : (k0_reg + KW'(1));
        c0  = fvcw_pkg::wheel_entry(k0_reg);
        c1  = fvcw_pkg::wheel_entry(k1);
        fw0 = 17'd65536 - {1'b0, f_reg};
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int b = 0; b < 3; b++)
            begin
                colx_reg[b] <= COLX_W'(fw0) * COLX_W'(c0[b]) +
                               COLX_W'(f_reg) * COLX_W'(c1[b]);
            end
        end
    end

    // Blended color waits for the normalized magnitude.
    logic [COLX_W-1:0] cd_reg [0:COL_LEN-1][3];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            cd_reg[0] <= colx_reg;
            for (int i = 1; i < COL_LEN; i++)
            begin
                cd_reg[i] <= cd_reg[i-1];
            end
        end
    end

    // Fade toward white inside the radius, darken outside it.
    logic [RQ_W-1:0]   rq_c;
    logic [PROD_W-1:0] prod_reg  [3];
    logic [7:0]        outer_reg [3];
    logic              inside3_reg;
    logic              inv3_reg;

    assign rq_c = (dq_reg[RQ_W-1] > fvcw_pkg::RQ_MAX) ? fvcw_pkg::RQ_MAX : dq_reg[RQ_W-1];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int b = 0; b < 3; b++)
            begin
                prod_reg[b]  <= PROD_W'(rq_c) *
                                (PROD_W'(24'd255 << 16) - PROD_W'(cd_reg[COL_LEN-1][b]));
                outer_reg[b] <= 8'((26'(cd_reg[COL_LEN-1][b]) * 26'd3) >> 18);
            end
            inside3_reg <= sb_inside_reg[SB_LEN-1];
            inv3_reg    <= sb_inv_reg[SB_LEN-1];
        end
    end

    // Output register.
    logic [PROD_W-1:0] fade [3];
    logic [7:0]        ch_reg [3];

    always_comb
    begin
        for (int b = 0; b < 3; b++)
        begin
            fade[b] = (PROD_W'(255) << 28) - prod_reg[b];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int b = 0; b < 3; b++)
            begin
                if (inv3_reg)
                begin
                    ch_reg[b] <= 8'd0;
                end
                else if (inside3_reg)
                begin
                    ch_reg[b] <= fade[b][35:28];
                end
                else
                begin
                    ch_reg[b] <= outer_reg[b];
                end
            end
        end
    end

    assign out_valid = val_reg[LAST];
    assign red       = ch_reg[0];
    assign green     = ch_reg[1];
    assign blue      = ch_reg[2];

endmodule

/* tb/flow_vector_to_color_wheel_core_test.sv */
// ============================================================================
// Flow color wheel core testbench
// Streams flow vectors through the core under random sender gaps and receiver
// stalls, predicts each color with an independent fixed-point model and checks
// every output beat in order against it.
// ============================================================================
module flow_vector_to_color_wheel_core_test;

    localparam int FW          = 20;
    localparam int RW          = fvcw_pkg::RAD_WIDTH;
    localparam int DRAIN_WAIT  = 60;
    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 300;
    localparam int ATAN_STEP [14] = '{8192, 4836, 2555, 1297, 651, 326, 163, 81,
                                      41, 20, 10, 5, 3, 1};
    localparam logic signed [FW-1:0] U_MAX = 20'sh7FFFF;
    localparam logic signed [FW-1:0] U_MIN = 20'sh80000;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_we;
    logic [RW-1:0]          cfg_wdata;
    logic                   in_valid;
    logic                   in_ready;
    logic signed [FW-1:0]   flow_u;
    logic signed [FW-1:0]   flow_v;
    logic                   flow_invalid;
    logic                   out_valid;
    logic                   out_ready;
    logic [7:0]             red;
    logic [7:0]             green;
    logic [7:0]             blue;

    logic [RW-1:0]          radius_setting;
    fvcw_pkg::rgb_t         color_q[$];
    int                     errors;
    int                     cycles;
    int                     stall_left;
    bit                     idle_on;
    bit                     hold_trigger;
    bit                     holding;

    flow_vector_to_color_wheel_core #(.FLOW_WIDTH(FW)) u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .flow_u       (flow_u),
        .flow_v       (flow_v),
        .flow_invalid (flow_invalid),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .red          (red),
        .green        (green),
        .blue         (blue)
    );

    // Clock generation.
    initial
    begin
        clk = 1'b0;
    end

    always #2 clk = ~clk;

    // Integer square root of a 64-bit value.
    function automatic longint unsigned int_sqrt(input longint unsigned n);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b = 64'd1 << 62;
        while (b > n)
            b = b >> 2;
        while (b != 0)
        begin
            if (n >= res + b)
            begin
                n = n - (res + b);
                res = (res >> 1) + b;
            end
            else
            begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    // One entry of the 55-entry hue wheel.
    function automatic fvcw_pkg::rgb_t hue_entry(input int k);
        fvcw_pkg::rgb_t c;
        c = '0;
        if (k < 15)
        begin
            c[0] = 8'd255; c[1] = 8'(255 * k / 15);
        end
        else if (k < 21)
        begin
            c[0] = 8'(255 - 255 * (k - 15) / 6); c[1] = 8'd255;
        end
        else if (k < 25)
        begin
            c[1] = 8'd255; c[2] = 8'(255 * (k - 21) / 4);
        end
        else if (k < 36)
        begin
            c[1] = 8'(255 - 255 * (k - 25) / 11); c[2] = 8'd255;
        end
        else if (k < 49)
        begin
            c[0] = 8'(255 * (k - 36) / 13); c[2] = 8'd255;
        end
        else
        begin
            if (k > 54)
                k = 54;
            c[0] = 8'd255; c[2] = 8'(255 - 255 * (k - 49) / 6);
        end
        return c;
    endfunction

    // Direction of the vector in 2^-16 turn, by octant folding and CORDIC.
    function automatic longint flow_phase(input longint u, input longint v);
        longint ax, ay, x, y, xs, ys, t, tmp, ph;
        bit     swapped;
        ax = (u < 0) ? -u : u;
        ay = (v < 0) ? -v : v;
        t = 0;
        swapped = 1'b0;
        if (ay > ax)
        begin
            tmp = ax; ax = ay; ay = tmp;
            swapped = 1'b1;
        end
        if (ax != 0)
        begin
            x = ax <<< 20;
            y = ay <<< 20;
            for (int i = 0; i < 14; i++)
            begin
                xs = x >>> i;
                ys = y >>> i;
                if (y >= 0)
                begin
                    x = x + ys; y = y - xs; t = t + ATAN_STEP[i];
                end
                else
                begin
                    x = x - ys; y = y + xs; t = t - ATAN_STEP[i];
                end
            end
            if (t < 0) t = 0;
            if (t > 8192) t = 8192;
        end
        if (swapped)
            t = 16384 - t;
        if (u >= 0 && v >= 0)
            ph = t;
        else if (u < 0 && v >= 0)
            ph = 32768 - t;
        else if (u < 0)
            ph = 32768 + t;
        else
            ph = 65536 - t;
        return ph & 64'hFFFF;
    endfunction

    // Expected color for one flow vector under the given radius.
    function automatic fvcw_pkg::rgb_t predict_color(input logic signed [FW-1:0] u_in,
                                                     input logic signed [FW-1:0] v_in,
                                                     input logic inv,
                                                     input logic [RW-1:0] rad);
        longint          u, v;
        longint unsigned r, sumsq, rq, p, colx, diff, ch;
        int              k0, k1, f;
        bit              in_radius;
        fvcw_pkg::rgb_t  c0, c1, o;
        o = '0;
        if (inv)
            return o;
        u = u_in;
        v = v_in;
        r = (rad == 0) ? 1 : rad;
        sumsq = u * u + v * v;
        in_radius = (sumsq <= r * r);
        rq = 0;
        if (in_radius)
        begin
            rq = int_sqrt(sumsq << 24) / r;
            if (rq > 4096)
                rq = 4096;
        end
        p = flow_phase(u, v) * 54;
        k0 = int'(p >> 16);
        f = int'(p & 64'hFFFF);
        k1 = (k0 + 1) % 55;
        c0 = hue_entry(k0);
        c1 = hue_entry(k1);
        for (int b = 0; b < 3; b++)
        begin
            colx = longint'(65536 - f) * c0[b] + longint'(f) * c1[b];
            if (in_radius)
            begin
                diff = (64'd255 << 16) - colx;
                ch = ((64'd255 << 28) - rq * diff) >> 28;
            end
            else
            begin
                ch = (3 * colx) >> 18;
            end
            o[b] = ch[7:0];
        end
        return o;
    endfunction

    // Send one flow vector beat after a random gap when idling is on.
    task automatic send_vector(input logic signed [FW-1:0] u,
                               input logic signed [FW-1:0] v,
                               input logic inv);
        int gap;
        gap = idle_on ? $urandom_range(0, 17) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid     <= 1'b1;
        flow_u       <= u;
        flow_v       <= v;
        flow_invalid <= inv;
        do
            @(posedge clk);
        while (!in_ready);
        color_q = {color_q, predict_color(u, v, inv, radius_setting)};
        @(negedge clk);
    endtask

    // Wait until every expected color has come out and the pipe is empty.
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (color_q.size() != 0)
            @(negedge clk);
        repeat (DRAIN_WAIT) @(negedge clk);
    endtask

    // Write the full-scale radius while the core is idle.
    task automatic set_radius(input logic [RW-1:0] rad);
        wait_drained();
        cfg_we    <= 1'b1;
        cfg_wdata <= rad;
        @(negedge clk);
        cfg_we    <= 1'b0;
        radius_setting = rad;
    endtask

    // Random flow vector, biased toward the inside of the radius.
    task automatic send_random_vector();
        logic signed [FW-1:0] u, v;
        int                   mode;
        int                   lim;
        mode = $urandom_range(0, 9);
        u = FW'($urandom);
        v = FW'($urandom);
        lim = (radius_setting > 370000) ? 370000 : radius_setting;
        if (mode < 5)
        begin
            u = FW'($urandom_range(0, lim));
            v = FW'($urandom_range(0, lim));
            if ($urandom_range(0, 1)) u = -u;
            if ($urandom_range(0, 1)) v = -v;
        end
        else if (mode == 5)
        begin
            if ($urandom_range(0, 1)) u = FW'(0); else v = FW'(0);
        end
        else if (mode == 6)
        begin
            v = $urandom_range(0, 1) ? u : -u;
        end
        send_vector(u, v, mode == 9);
    endtask

    // Directed extremes, axes, diagonals, zero and unknown vectors.
    task automatic test_directed();
        idle_on = 1'b0;
        send_vector(20'sd0, 20'sd0, 1'b0);
        send_vector(20'sd0, 20'sd0, 1'b1);
        send_vector(U_MAX, U_MAX, 1'b1);
        send_vector(U_MAX, 20'sd0, 1'b0);
        send_vector(U_MIN, 20'sd0, 1'b0);
        send_vector(20'sd0, U_MAX, 1'b0);
        send_vector(20'sd0, U_MIN, 1'b0);
        send_vector(U_MIN, U_MIN, 1'b0);
        send_vector(U_MAX, U_MIN, 1'b0);
        send_vector(U_MIN, U_MAX, 1'b0);
        send_vector(20'sd7680, 20'sd0, 1'b0);
        send_vector(20'sd7681, 20'sd0, 1'b0);
        send_vector(20'sd3840, -20'sd3840, 1'b0);
        send_vector(-20'sd3840, 20'sd3840, 1'b0);
        send_vector(20'sd1, 20'sd0, 1'b0);
        send_vector(-20'sd1, -20'sd1, 1'b0);
        send_vector(20'sd2000, 20'sd5000, 1'b0);
        send_vector(-20'sd5000, -20'sd2000, 1'b0);
        send_vector(20'sd1, -20'sd1, 1'b0);
        send_vector(-20'sd7680, 20'sd1, 1'b0);
    endtask

    // Radius extremes, including zero which acts as one.
    task automatic test_radius_extremes();
        logic [RW-1:0] rads [4];
        rads = '{19'd0, 19'd1, 19'h7FFFF, 19'd256};
        idle_on = 1'b1;
        foreach (rads[i])
        begin
            set_radius(rads[i]);
            send_vector(20'sd0, 20'sd0, 1'b0);
            send_vector(20'sd1, 20'sd0, 1'b0);
            send_vector(20'sd0, -20'sd1, 1'b0);
            send_vector(U_MIN, U_MIN, 1'b0);
            send_vector(20'sd300000, -20'sd300000, 1'b0);
            repeat (5) send_random_vector();
        end
    endtask

    // Random vectors over several radius settings, idling toggled in stretches.
    task automatic test_random_stream();
        logic [RW-1:0] rads [5];
        rads = '{19'd7680, 19'd100000, 19'd2, 19'h7FFFF, 19'd1000};
        foreach (rads[i])
        begin
            set_radius(rads[i]);
            for (int n = 0; n < 60; n++)
            begin
                if (n % 20 == 0)
                    idle_on = $urandom_range(0, 2) != 0;
                send_random_vector();
            end
        end
    endtask

    // Receiver holds off for a long stretch while the sender keeps pushing.
    task automatic test_backpressure();
        set_radius(fvcw_pkg::RADIUS_RESET);
        idle_on = 1'b0;
        hold_trigger = 1'b1;
        repeat (80) send_random_vector();
        idle_on = 1'b1;
        repeat (10) send_random_vector();
    endtask

    // Long receiver hold-off, counted in its own process.
    initial
    begin
        holding = 1'b0;
        forever
        begin
            wait (hold_trigger);
            hold_trigger = 1'b0;
            holding = 1'b1;
            repeat (HOLD_CYCLES) @(negedge clk);
            holding = 1'b0;
        end
    end

    // Receiver ready with random stalls between beats.
    always @(negedge clk)
    begin
        if (holding || stall_left > 0)
        begin
            out_ready <= 1'b0;
            if (stall_left > 0)
                stall_left <= stall_left - 1;
        end
        else
        begin
            out_ready <= 1'b1;
        end
    end

    // Compare each accepted color with the oldest expectation.
    always @(posedge clk)
    begin
        fvcw_pkg::rgb_t exp_c;
        if (rst_n && out_valid && out_ready)
        begin
            stall_left <= idle_on ? $urandom_range(0, 17) : 0;
            if (color_q.size() == 0)
            begin
                $display("%0t: unexpected color beat r=%0d g=%0d b=%0d",
                         $time, red, green, blue);
                errors++;
            end
            else
            begin
                exp_c = color_q.pop_front();
                if (red !== exp_c[0])
                begin
                    $display("%0t: red expected %0d actual %0d", $time, exp_c[0], red);
                    errors++;
                end
                if (green !== exp_c[1])
                begin
                    $display("%0t: green expected %0d actual %0d", $time, exp_c[1], green);
                    errors++;
                end
                if (blue !== exp_c[2])
                begin
                    $display("%0t: blue expected %0d actual %0d", $time, exp_c[2], blue);
                    errors++;
                end
            end
        end
    end

    // Run limit.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Test sequence.
    initial
    begin
        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_wdata      = '0;
        in_valid       = 1'b0;
        flow_u         = '0;
        flow_v         = '0;
        flow_invalid   = 1'b0;
        out_ready      = 1'b0;
        stall_left     = 0;
        errors         = 0;
        cycles         = 0;
        idle_on        = 1'b0;
        hold_trigger   = 1'b0;
        radius_setting = fvcw_pkg::RADIUS_RESET;
        repeat (11) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        test_directed();
        test_radius_extremes();
        test_random_stream();
        test_backpressure();
        wait_drained();
        if (errors == 0 && color_q.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

/* sim.f */
hw/rtl/fvcw_pkg.sv
hw/rtl/fvcw_cordic.sv
hw/rtl/fvcw_isqrt.sv
hw/rtl/flow_vector_to_color_wheel_core.sv
tb/flow_vector_to_color_wheel_core_test.sv
